/* src/deq_pkg.sv */
package deq_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_VALUE_BITS = 32;
  localparam int DATA_W         = 32;
  localparam int OP_W           = 3;
  localparam int STATUS_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_LOOK      = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LOAD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic read;
    logic load_out;
  } deq_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic out_free;
  } deq_stat_t;

endpackage

/* src/deq_ctrl.sv */
module deq_ctrl
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  deq_stat_t stat,
  output deq_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        // Wait here until the output register can take the new transaction.
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/deq_datapath.sv */
module deq_datapath
  import deq_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  deq_cmd_t                 cmd,
  output deq_stat_t                stat,
  input  logic [OP_W-1:0]          operation,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] front_value,
  output logic signed [DATA_W-1:0] back_value,
  output logic [CNT_W-1:0]         entry_count,
  output logic [STATUS_W-1:0]      status
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic [VALUE_BITS-1:0] mem [CAPACITY];

  op_t                   op_q;
  logic [DATA_W-1:0]     value_q;
  logic [IDX_W-1:0]      front_index;
  logic [CNT_W-1:0]      stored_count;
  status_t               status_q;
  logic [VALUE_BITS-1:0] rd_front;
  logic [VALUE_BITS-1:0] rd_back;

  logic [VALUE_BITS-1:0] wr_data;
  logic [IDX_W-1:0]      front_dec;
  logic [IDX_W-1:0]      tail_slot;
  logic [IDX_W-1:0]      back_slot;
  logic [SUM_W-1:0]      tail_sum;
  logic [SUM_W-1:0]      back_sum;
  logic [DATA_W-1:0]     front_ext;
  logic [DATA_W-1:0]     back_ext;
  logic                  is_empty;

  // Width conversion between the 32-bit ports and the stored value.
  if (VALUE_BITS <= DATA_W) begin : g_wr_narrow
    assign wr_data = value_q[VALUE_BITS-1:0];
  end else begin : g_wr_wide
    assign wr_data = {{(VALUE_BITS - DATA_W){value_q[DATA_W-1]}}, value_q};
  end

  if (VALUE_BITS >= DATA_W) begin : g_rd_wide
    assign front_ext = rd_front[DATA_W-1:0];
    assign back_ext  = rd_back[DATA_W-1:0];
  end else begin : g_rd_narrow
    assign front_ext = {{(DATA_W - VALUE_BITS){rd_front[VALUE_BITS-1]}}, rd_front};
    assign back_ext  = {{(DATA_W - VALUE_BITS){rd_back[VALUE_BITS-1]}}, rd_back};
  end

  // Ring arithmetic: each sum stays below twice the capacity, so one
  // compare and subtract brings it back into range.
  always_comb begin
    front_dec = (front_index == '0) ? LAST_IDX : front_index - IDX_W'(1);
    tail_sum  = SUM_W'(front_index) + SUM_W'(stored_count);
    if (tail_sum >= CAP_SUM) begin
      tail_sum = tail_sum - CAP_SUM;
    end
    tail_slot = tail_sum[IDX_W-1:0];
    is_empty  = (stored_count == '0);
    back_sum  = SUM_W'(front_index) + SUM_W'(stored_count) - SUM_W'(1);
    if (back_sum >= CAP_SUM) begin
      back_sum = back_sum - CAP_SUM;
    end
    back_slot = is_empty ? front_index : back_sum[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q    <= op_t'(operation);
      value_q <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index  <= '0;
      stored_count <= '0;
    end else if (cmd.exec) begin
      case (op_q)
        OP_INS_FRONT: begin
          if (stored_count != CAP_CNT) begin
            front_index  <= front_dec;
            stored_count <= stored_count + CNT_W'(1);
          end
        end
        OP_INS_BACK: begin
          if (stored_count != CAP_CNT) begin
            stored_count <= stored_count + CNT_W'(1);
          end
        end
        OP_REM_FRONT: begin
          if (!is_empty) begin
            front_index  <= (front_index == LAST_IDX) ? '0 : front_index + IDX_W'(1);
            stored_count <= stored_count - CNT_W'(1);
          end
        end
        OP_REM_BACK: begin
          if (!is_empty) begin
            stored_count <= stored_count - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          front_index  <= '0;
          stored_count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_q <= ST_DONE;
      case (op_q)
        OP_INS_FRONT, OP_INS_BACK: begin
          if (stored_count == CAP_CNT) begin
            status_q <= ST_FULL;
          end
        end
        OP_REM_FRONT, OP_REM_BACK: begin
          if (is_empty) begin
            status_q <= ST_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.exec && stored_count != CAP_CNT) begin
      if (op_q == OP_INS_FRONT) begin
        mem[front_dec] <= wr_data;
      end else if (op_q == OP_INS_BACK) begin
        mem[tail_slot] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_front <= mem[front_index];
      rd_back  <= mem[back_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      front_value <= is_empty ? '0 : front_ext;
      back_value  <= is_empty ? '0 : back_ext;
      entry_count <= stored_count;
      status      <= status_q;
    end
  end

  assign stat.out_free = !out_valid || !out_stall;

endmodule

/* src/double_ended_queue_unit.sv */
// Channel | Handshake            | Payload
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_stall  | operation, value
// out     | out_valid / out_stall| front_value, back_value, entry_count, status
//
// Each input transaction goes through accept, queue update with the store write,
// the registered read of the front and back slots, and the load of the output register.
// The next transaction is accepted only after the current one has been loaded.
// A result waiting in the output register does not block the next input transaction;
// only the output load waits while out_stall holds a full register.
// Reset (rst, synchronous) empties the queue; the store is not cleared, as only occupied
// slots are ever read.
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          operation,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] front_value,
  output logic signed [DATA_W-1:0] back_value,
  output logic [CNT_W-1:0]         entry_count,
  output logic [STATUS_W-1:0]      status
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  // The controller sequences one transaction at a time through the datapath.
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the ring store, the front index, the count and the
  // output register.
  deq_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .front_value (front_value),
    .back_value  (back_value),
    .entry_count (entry_count),
    .status      (status)
  );

endmodule

/* src/deq_checker.sv */
module deq_checker
  import deq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] front_value,
  input logic signed [DATA_W-1:0] back_value,
  input logic [CNT_W-1:0]         entry_count,
  input logic [STATUS_W-1:0]      status
);

  // A held result keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(front_value) && $stable(back_value)
      && $stable(entry_count) && $stable(status))
    else $error("stalled result changed");

  // Only one transaction is in flight, so an accept closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_count == '0 |-> front_value == '0 && back_value == '0)
    else $error("empty queue shows nonzero values");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> entry_count == '0)
    else $error("empty status with entries present");

endmodule

bind double_ended_queue_unit deq_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

/* sim/double_ended_queue_unit_test.sv */
module double_ended_queue_unit_test;
  import deq_pkg::*;

  // The bench runs the unit with its default size. Because the capacity is a
  // power of two, ring positions are taken modulo CAPACITY.
  localparam int CAPACITY = DEF_CAPACITY;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  // The settle time at the end is longer than one transaction in the unit. The
  // cycle limit is many times the slowest correct run: about 1950 transactions,
  // each with the longest sender gap, the work in the unit and the longest
  // receiver stall.
  localparam int SETTLE_CYCLES  = 20;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int SEGMENT_ITEMS  = 100;
  localparam int SEGMENTS       = 19;
  localparam int QUIET_SEGMENTS = 2;
  localparam int REPORT_LIMIT   = 10;

  // Operation codes 6 and 7 have no name in the package. The unit must treat
  // them as a look.
  localparam logic [OP_W-1:0] OP_SPARE_LOW  = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HIGH = 3'd7;

  localparam logic [DATA_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] ALL_ONES      = 32'hFFFF_FFFF;

  // The mix of operations in one random segment. A filling segment drives the
  // queue into the full store, and a draining segment drives it into the empty
  // queue.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } op_mix_t;

  // One result of the unit, as the predictor works it out.
  typedef struct packed {
    logic [DATA_W-1:0] front;
    logic [DATA_W-1:0] back;
    logic [CNT_W-1:0]  count;
    status_t           status;
  } deque_view_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic out_stall = 1'b0;
  logic [OP_W-1:0] operation = '0;
  logic signed [DATA_W-1:0] value = '0;

  logic in_stall;
  logic out_valid;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [CNT_W-1:0] entry_count;
  logic [STATUS_W-1:0] status;

  // The predictor keeps its own copy of the ring, the front index and the
  // entry count. Slots that were never written are never read, because only
  // occupied slots feed the front and back values.
  logic [DATA_W-1:0] ring [CAPACITY];
  logic [IDX_W-1:0]  head   = '0;
  logic [CNT_W-1:0]  stored = '0;

  // Results that are predicted but have not yet arrived, oldest first.
  deque_view_t due_results [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned stall_left     = 0;
  bit          idling         = 1'b1;

  double_ended_queue_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .front_value (front_value),
    .back_value  (back_value),
    .entry_count (entry_count),
    .status      (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // This is a watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[double_ended_queue_unit] ERROR");
      $finish;
    end
  end

  // The receiver stalls in random bursts. Each burst lowers the stall only
  // when it ends, so the stall gets at most one update in any time step. When
  // idling is switched off, the running burst finishes and no new burst starts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      if (stall_left == 0) begin
        out_stall <= 1'b0;
      end
    end else if (idling && !rst && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4);
      out_stall <= 1'b1;
    end
  end

  function automatic int unsigned ring_slot(input int unsigned offset);
    return (int'(head) + offset) % CAPACITY;
  endfunction

  // This task applies one accepted transaction to the predicted queue and then
  // queues the result that the unit must return for it. The value width of the
  // unit equals the port width, so a stored value comes back unchanged.
  task automatic predict_deque_view(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data);
    deque_view_t view;
    view.status = ST_DONE;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (stored == CAPACITY) begin
          view.status = ST_FULL;
        end else begin
          if (op == OP_INS_FRONT) begin
            head = IDX_W'(ring_slot(CAPACITY - 1));
            ring[head] = data;
          end else begin
            ring[ring_slot(stored)] = data;
          end
          stored = stored + 1'b1;
        end
      end
      OP_REM_FRONT, OP_REM_BACK: begin
        if (stored == 0) begin
          view.status = ST_EMPTY;
        end else begin
          if (op == OP_REM_FRONT) begin
            head = IDX_W'(ring_slot(1));
          end
          stored = stored - 1'b1;
        end
      end
      OP_CLEAR: begin
        stored = '0;
        head   = '0;
      end
      default: begin
        // A look and the two spare codes leave the queue as it is.
      end
    endcase
    if (stored == 0) begin
      view.front = '0;
      view.back  = '0;
    end else begin
      view.front = ring[head];
      view.back  = ring[ring_slot(stored - 1)];
    end
    view.count = stored;
    due_results.push_back(view);
  endtask

  // This task sends one transaction. It may first open a random gap. The valid
  // stays high from one transaction to the next unless a gap or a wait lowers
  // it, so it never gets two updates in one time step.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data);
    int unsigned gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= data;
    do @(posedge clk); while (in_stall);
    predict_deque_view(op, data);
  endtask

  // The sender holds off until every predicted result has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input deque_view_t want);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%s: expected front %h back %h count %0d status %0d,",
               what, want.front, want.back, want.count, want.status);
      $display("  got front %h back %h count %0d status %0d",
               front_value, back_value, entry_count, status);
    end
  endtask

  // Each result that the unit hands over is compared field by field with the
  // oldest prediction. A result that arrives with no prediction waiting is a
  // failure too.
  always @(posedge clk) begin : check_results
    deque_view_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        want = '0;
        report_mismatch("unexpected result", want);
      end else begin
        want = due_results.pop_front();
        if (front_value !== want.front || back_value !== want.back ||
            entry_count !== want.count || status !== want.status) begin
          report_mismatch("result mismatch", want);
        end
      end
    end
  end

  // These are looks and removes on the empty queue after reset.
  task automatic test_empty_queue();
    send_item(OP_LOOK, ALL_ONES);
    send_item(OP_REM_FRONT, '0);
    send_item(OP_REM_BACK, MOST_NEGATIVE);
  endtask

  // The extremes of the value range are inserted at both ends and then removed
  // from both ends. The last remove hits the empty queue again.
  task automatic test_value_extremes();
    send_item(OP_INS_FRONT, MOST_NEGATIVE);
    send_item(OP_INS_BACK, MOST_POSITIVE);
    send_item(OP_INS_FRONT, ALL_ONES);
    send_item(OP_INS_BACK, '0);
    send_item(OP_LOOK, 32'h1234_5678);
    send_item(OP_REM_FRONT, '0);
    send_item(OP_REM_BACK, '0);
    send_item(OP_REM_FRONT, '0);
    send_item(OP_REM_BACK, '0);
    send_item(OP_REM_BACK, '0);
  endtask

  // The spare codes must act as a look, whatever value comes with them.
  task automatic test_unused_codes();
    send_item(OP_INS_BACK, 32'h0000_0001);
    send_item(OP_SPARE_LOW, ALL_ONES);
    send_item(OP_SPARE_HIGH, 32'hAAAA_AAAA);
  endtask

  // A clear resets the front index. The insert at the front that follows must
  // therefore wrap to the last slot of the ring.
  task automatic test_clear_and_wrap();
    send_item(OP_INS_FRONT, 32'h5555_5555);
    send_item(OP_CLEAR, ALL_ONES);
    send_item(OP_LOOK, '0);
    send_item(OP_INS_FRONT, 32'hCAFE_F00D);
    send_item(OP_INS_BACK, 32'hFFFF_FFFE);
    send_item(OP_REM_FRONT, '0);
    send_item(OP_REM_FRONT, '0);
    send_item(OP_REM_FRONT, '0);
  endtask

  function automatic logic [OP_W-1:0] pick_operation(input op_mix_t mix);
    int unsigned roll = $urandom_range(0, 199);
    int unsigned insert_pct;
    case (mix)
      MIX_FILL:  insert_pct = 95;
      MIX_DRAIN: insert_pct = 5;
      default:   insert_pct = 50;
    endcase
    if (roll == 0) begin
      return OP_CLEAR;
    end else if (roll < 5) begin
      return $urandom_range(0, 1) ? OP_SPARE_HIGH : OP_SPARE_LOW;
    end else if (roll < 15) begin
      return OP_LOOK;
    end else if ($urandom_range(0, 99) < insert_pct) begin
      return $urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT;
    end
    return $urandom_range(0, 1) ? OP_REM_BACK : OP_REM_FRONT;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return MOST_NEGATIVE;
      1:       return MOST_POSITIVE;
      2:       return '0;
      3:       return ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  // The random traffic comes in segments that fill, drain and wander in turn.
  // This drives the queue into the full store and the empty queue many times,
  // and the ring wraps in both directions. The last segments run with no
  // idling on either side.
  task automatic test_random_traffic();
    op_mix_t mix;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == SEGMENTS - QUIET_SEGMENTS) begin
        wait_for_results();
        idling = 1'b0;
      end
      case (seg % 3)
        0:       mix = MIX_FILL;
        1:       mix = MIX_DRAIN;
        default: mix = MIX_EVEN;
      endcase
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        send_item(pick_operation(mix), pick_value());
      end
    end
  endtask

  initial begin : run_tests
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_value_extremes();
    test_unused_codes();
    test_clear_and_wrap();
    wait_for_results();
    test_random_traffic();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("[double_ended_queue_unit] OK");
    end else begin
      $display("[double_ended_queue_unit] ERROR");
    end
    $finish;
  end

endmodule

/* double_ended_queue_unit.f */
src/deq_pkg.sv
src/deq_ctrl.sv
src/deq_datapath.sv
src/double_ended_queue_unit.sv
src/deq_checker.sv
sim/double_ended_queue_unit_test.sv
